// ===== hdl/bits_pkg.sv =====
`timescale 1ns / 1ps

package bits_pkg;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned PWR_W  = 17;
  localparam int unsigned INV_W  = 33;
  localparam int unsigned S_W    = 33;
  localparam int unsigned DISP_W = 43;
  localparam int unsigned C_W    = 44;
  localparam int unsigned OP_W   = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned SQ_W   = 31;
  localparam int unsigned TIME_W = 7;

  localparam logic [PWR_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic signed [C_W-1:0] POS_MAX = 44'sd8388607;
  localparam logic signed [C_W-1:0] POS_MIN = -44'sd8388608;

  localparam logic [1:0] CFG_DECAY  = 2'd0;
  localparam logic [1:0] CFG_RADIUS = 2'd1;
  localparam logic [1:0] CFG_SPEED  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_D0, ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_D6,
    ST_D7, ST_D8, ST_D9, ST_D10, ST_D11, ST_D12, ST_D13,
    ST_SQ0, ST_SQ1,
    ST_LOWRD, ST_LOWGET,
    ST_PMRD, ST_PMMUL, ST_PMRND,
    ST_LOOP, ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    MD_TEST0,
    MD_TEST1,
    MD_DOUBLE,
    MD_BISECT,
    MD_EMIT
  } mode_e;

endpackage

// ===== hdl/ball_intercept_time_search.sv =====
`timescale 1ns / 1ps

// Ball intercept time search.
// Configuration: cfg_we_i / cfg_idx_i / cfg_data_i write decay (0), reach radius (1)
// or top speed (2); the user must write only while busy is low (not enforced by the
// block). A decay write starts a reciprocal divide, during which busy stays high.
// Command: a beat is taken when start is high and busy is low; ball, velocity and
// player positions are sampled then. busy stays high until the result is formed.
// Result: done_o is high for exactly one cycle with intercept_time_o, intercept_x_o
// and intercept_y_o; the receiver cannot stall, so the result must be taken then.
// Search: each reach test steps through ST_D0 to ST_D13 on the one shared 32x32
// multiplier; the count of tests an item makes is set by the doubling and bisection
// phases. One item is in flight at a time.
// Reset: registers return to their defaults and the reciprocal is formed
// again (busy high meanwhile) before the first beat is taken.
module ball_intercept_time_search #(
  parameter int unsigned SEARCH_LEVELS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] ball_x_i,
  input  logic signed [23:0] ball_y_i,
  input  logic signed [23:0] ball_vel_x_i,
  input  logic signed [23:0] ball_vel_y_i,
  input  logic signed [23:0] player_x_i,
  input  logic signed [23:0] player_y_i,
  output logic               done_o,
  output logic [6:0]         intercept_time_o,
  output logic signed [23:0] intercept_x_o,
  output logic signed [23:0] intercept_y_o
);

  localparam int unsigned TW = SEARCH_LEVELS - 1;
  localparam int unsigned IW = $clog2(SEARCH_LEVELS + 1);
  localparam int unsigned AW = $clog2(SEARCH_LEVELS);
  localparam int unsigned RW = SEARCH_LEVELS + 23;
  localparam int unsigned KW = $clog2(RW);
  localparam int unsigned PW = bits_pkg::PWR_W;
  localparam int unsigned CW = bits_pkg::C_W;
  localparam int unsigned DW = bits_pkg::DISP_W;

  bits_pkg::state_e state_q, state_d;
  bits_pkg::mode_e  mode_q;

  logic [IW-1:0] i_q, j_q;
  logic          pend_q, done_q;

  logic [15:0]        decay_q;
  logic signed [23:0] radius_q;
  logic [22:0]        speed_q;

  logic signed [23:0] bx_q, by_q, vx_q, vy_q, px_q, py_q;
  logic [PW-1:0] p_q, low_pw_q, mid_pw_q, high_pw_q;
  logic [TW-1:0] t_q, low_st_q, mid_st_q, high_st_q;

  logic [bits_pkg::PROD_W-1:0] prod_q, acc_q;
  logic [bits_pkg::S_W-1:0]    s_q;
  logic signed [RW-1:0]        reach_q;
  logic signed [DW-1:0]        dx_q, dy_q;
  logic [CW-1:0]               ax_q, ay_q;
  logic [bits_pkg::SQ_W-1:0]   axs_q, ays_q, rs_q;
  logic                        miss_q;

  logic [6:0]         time_q;
  logic signed [23:0] ox_q, oy_q;

  logic [bits_pkg::OP_W-1:0]   mul_a, mul_b;
  logic [bits_pkg::PROD_W-1:0] mul_p;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [15:0]                 ram_wdata, ram_rdata;
  logic                        div_start, div_busy;
  logic [bits_pkg::INV_W-1:0]  inv;

  logic [PW-1:0]        g, sq_rnd;
  logic [23:0]          vxa, vya;
  logic [bits_pkg::PROD_W-1:0] wide_sum;
  logic                 hit, accept, limit;
  logic signed [RW-1:0] rad_ext;
  logic [RW-2:0]        r_mag;
  logic [KW-1:0]        k;
  logic signed [CW-1:0] cx, cy, ex, ey;

  function automatic logic [TW-1:0] step_of(input logic [IW-1:0] n);
    step_of = (n == '0) ? '0 : (TW'(1) << (n - IW'(1)));
  endfunction

  function automatic logic signed [DW-1:0] rnd16(input logic [63:0] mag, input logic neg);
    logic [63:0] r;
    r = (mag + 64'd32768) >> 16;
    rnd16 = neg ? -DW'(r) : DW'(r);
  endfunction

  function automatic logic [23:0] sat(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] c;
    c = v;
    if (c > bits_pkg::POS_MAX) c = bits_pkg::POS_MAX;
    if (c < bits_pkg::POS_MIN) c = bits_pkg::POS_MIN;
    sat = c[23:0];
  endfunction

  bits_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .gap_i   (bits_pkg::ONE_Q16 - PW'(decay_q)),
    .busy_o  (div_busy),
    .recip_o (inv)
  );

  bits_ram #(
    .WIDTH (16),
    .DEPTH (SEARCH_LEVELS)
  ) u_pow_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign mul_p  = mul_a * mul_b;
  assign busy   = (state_q != bits_pkg::ST_IDLE) || pend_q || div_busy;
  assign accept = start && !busy;
  assign div_start = pend_q && !div_busy && (state_q == bits_pkg::ST_IDLE);

  assign g        = bits_pkg::ONE_Q16 - p_q;
  assign vxa      = vx_q[23] ? 24'(-vx_q) : 24'(vx_q);
  assign vya      = vy_q[23] ? 24'(-vy_q) : 24'(vy_q);
  assign wide_sum = acc_q + (prod_q << 17);
  assign sq_rnd   = PW'((prod_q + 64'd32768) >> 16);
  assign hit      = !miss_q && (acc_q <= prod_q);
  assign limit    = (32'(i_q) + 32'd1) >= SEARCH_LEVELS;
  assign rad_ext  = RW'(radius_q);
  assign r_mag    = reach_q[RW-2:0];
  assign cx       = CW'(bx_q) + CW'(dx_q) - CW'(px_q);
  assign cy       = CW'(by_q) + CW'(dy_q) - CW'(py_q);
  assign ex       = (mode_q == bits_pkg::MD_TEST1) ? CW'(bx_q) + CW'(vx_q)
                                                   : CW'(bx_q) + CW'(dx_q);
  assign ey       = (mode_q == bits_pkg::MD_TEST1) ? CW'(by_q) + CW'(vy_q)
                                                   : CW'(by_q) + CW'(dy_q);

  always_comb begin
    k = '0;
    for (int b = 31; b < int'(RW) - 1; b++) begin
      if (r_mag[b]) k = KW'(b - 30);
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_a     = '0;
    mul_b     = '0;
    ram_we    = 1'b0;
    ram_waddr = i_q[AW-1:0];
    ram_wdata = sq_rnd[15:0];
    ram_raddr = i_q[AW-1:0];
    case (state_q)
      bits_pkg::ST_IDLE: begin
        if (accept) state_d = bits_pkg::ST_D0;
      end
      bits_pkg::ST_D0: begin
        mul_a = 32'(g); mul_b = 32'(inv[16:0]);
        state_d = bits_pkg::ST_D1;
      end
      bits_pkg::ST_D1: begin
        mul_a = 32'(g); mul_b = 32'(inv[32:17]);
        state_d = bits_pkg::ST_D2;
      end
      bits_pkg::ST_D2: begin
        mul_a = 32'(t_q); mul_b = 32'(speed_q);
        state_d = bits_pkg::ST_D3;
      end
      bits_pkg::ST_D3: begin
        mul_a = 32'(vxa); mul_b = 32'(s_q[16:0]);
        state_d = bits_pkg::ST_D4;
      end
      bits_pkg::ST_D4: begin
        mul_a = 32'(vxa); mul_b = 32'(s_q[32:17]);
        state_d = bits_pkg::ST_D5;
      end
      bits_pkg::ST_D5: begin
        mul_a = 32'(vya); mul_b = 32'(s_q[16:0]);
        state_d = bits_pkg::ST_D6;
      end
      bits_pkg::ST_D6: begin
        mul_a = 32'(vya); mul_b = 32'(s_q[32:17]);
        state_d = bits_pkg::ST_D7;
      end
      bits_pkg::ST_D7: begin
        state_d = (mode_q == bits_pkg::MD_EMIT) ? bits_pkg::ST_OUT : bits_pkg::ST_D8;
      end
      bits_pkg::ST_D8:  state_d = bits_pkg::ST_D9;
      bits_pkg::ST_D9:  state_d = bits_pkg::ST_D10;
      bits_pkg::ST_D10: begin
        mul_a = 32'(axs_q); mul_b = 32'(axs_q);
        state_d = bits_pkg::ST_D11;
      end
      bits_pkg::ST_D11: begin
        mul_a = 32'(ays_q); mul_b = 32'(ays_q);
        state_d = bits_pkg::ST_D12;
      end
      bits_pkg::ST_D12: begin
        mul_a = 32'(rs_q); mul_b = 32'(rs_q);
        state_d = bits_pkg::ST_D13;
      end
      bits_pkg::ST_D13: begin
        case (mode_q)
          bits_pkg::MD_TEST0: begin
            if (hit) begin
              state_d = bits_pkg::ST_OUT;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(1);
              ram_wdata = decay_q;
              state_d   = bits_pkg::ST_D0;
            end
          end
          bits_pkg::MD_TEST1: state_d = hit ? bits_pkg::ST_OUT : bits_pkg::ST_SQ0;
          bits_pkg::MD_DOUBLE: begin
            if (hit) state_d = bits_pkg::ST_LOWRD;
            else     state_d = limit ? bits_pkg::ST_D0 : bits_pkg::ST_SQ0;
          end
          default: state_d = bits_pkg::ST_PMRD;
        endcase
      end
      bits_pkg::ST_SQ0: begin
        mul_a = 32'(p_q); mul_b = 32'(p_q);
        state_d = bits_pkg::ST_SQ1;
      end
      bits_pkg::ST_SQ1: begin
        ram_we  = 1'b1;
        state_d = bits_pkg::ST_D0;
      end
      bits_pkg::ST_LOWRD:  state_d = bits_pkg::ST_LOWGET;
      bits_pkg::ST_LOWGET: state_d = bits_pkg::ST_PMRD;
      bits_pkg::ST_PMRD: begin
        ram_raddr = j_q[AW-1:0];
        state_d   = bits_pkg::ST_PMMUL;
      end
      bits_pkg::ST_PMMUL: begin
        mul_a = 32'(low_pw_q);
        mul_b = (j_q == '0) ? 32'(bits_pkg::ONE_Q16) : 32'(ram_rdata);
        state_d = bits_pkg::ST_PMRND;
      end
      bits_pkg::ST_PMRND: state_d = bits_pkg::ST_LOOP;
      bits_pkg::ST_LOOP:  state_d = bits_pkg::ST_D0;
      bits_pkg::ST_OUT:   state_d = bits_pkg::ST_IDLE;
      default:            state_d = bits_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bits_pkg::ST_IDLE;
      mode_q   <= bits_pkg::MD_TEST0;
      i_q      <= '0;
      j_q      <= '0;
      pend_q   <= 1'b1;
      done_q   <= 1'b0;
      decay_q  <= 16'd62259;
      radius_q <= 24'sd1638;
      speed_q  <= 23'd16384;
    end else begin
      state_q <= state_d;
      done_q  <= state_q == bits_pkg::ST_OUT;
      if (div_start) pend_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bits_pkg::CFG_DECAY: begin
            decay_q <= cfg_data_i[15:0];
            pend_q  <= 1'b1;
          end
          bits_pkg::CFG_RADIUS: radius_q <= cfg_data_i;
          bits_pkg::CFG_SPEED:  speed_q  <= cfg_data_i[22:0];
          default: ;
        endcase
      end
      case (state_q)
        bits_pkg::ST_IDLE: if (accept) mode_q <= bits_pkg::MD_TEST0;
        bits_pkg::ST_D13: begin
          case (mode_q)
            bits_pkg::MD_TEST0: if (!hit) mode_q <= bits_pkg::MD_TEST1;
            bits_pkg::MD_TEST1: if (!hit) i_q <= IW'(2);
            bits_pkg::MD_DOUBLE: begin
              if (hit)        i_q    <= i_q - IW'(1);
              else if (limit) mode_q <= bits_pkg::MD_EMIT;
              else            i_q    <= i_q + IW'(1);
            end
            default: j_q <= i_q - IW'(2);
          endcase
        end
        bits_pkg::ST_SQ1:    mode_q <= bits_pkg::MD_DOUBLE;
        bits_pkg::ST_LOWGET: j_q    <= i_q - IW'(1);
        bits_pkg::ST_PMRND:  i_q    <= j_q + IW'(1);
        bits_pkg::ST_LOOP: begin
          mode_q <= (i_q > IW'(1)) ? bits_pkg::MD_BISECT : bits_pkg::MD_EMIT;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      bits_pkg::ST_IDLE: begin
        if (accept) begin
          bx_q <= ball_x_i;     by_q <= ball_y_i;
          vx_q <= ball_vel_x_i; vy_q <= ball_vel_y_i;
          px_q <= player_x_i;   py_q <= player_y_i;
          p_q  <= bits_pkg::ONE_Q16;
          t_q  <= '0;
        end
      end
      bits_pkg::ST_D1:  acc_q <= prod_q;
      bits_pkg::ST_D2:  s_q <= bits_pkg::S_W'((wide_sum + 64'd32768) >> 16);
      bits_pkg::ST_D3:  reach_q <= $signed({1'b0, prod_q[RW-2:0]}) + rad_ext;
      bits_pkg::ST_D4:  acc_q <= prod_q;
      bits_pkg::ST_D5:  dx_q <= rnd16(wide_sum, vx_q[23]);
      bits_pkg::ST_D6:  acc_q <= prod_q;
      bits_pkg::ST_D7:  dy_q <= rnd16(wide_sum, vy_q[23]);
      bits_pkg::ST_D8: begin
        ax_q <= cx[CW-1] ? CW'(-cx) : CW'(cx);
        ay_q <= cy[CW-1] ? CW'(-cy) : CW'(cy);
      end
      bits_pkg::ST_D9: begin
        miss_q <= reach_q[RW-1] || (64'(ax_q) > 64'(r_mag)) || (64'(ay_q) > 64'(r_mag));
        axs_q  <= bits_pkg::SQ_W'(ax_q >> k);
        ays_q  <= bits_pkg::SQ_W'(ay_q >> k);
        rs_q   <= bits_pkg::SQ_W'(r_mag >> k);
      end
      bits_pkg::ST_D11: acc_q <= prod_q;
      bits_pkg::ST_D12: acc_q <= acc_q + prod_q;
      bits_pkg::ST_D13: begin
        case (mode_q)
          bits_pkg::MD_TEST0: begin
            if (!hit) begin
              p_q <= PW'(decay_q);
              t_q <= TW'(1);
            end
          end
          bits_pkg::MD_DOUBLE: begin
            if (hit) begin
              high_pw_q <= p_q;
              high_st_q <= t_q;
            end
          end
          bits_pkg::MD_BISECT: begin
            if (hit) begin
              high_pw_q <= mid_pw_q;
              high_st_q <= mid_st_q;
            end else begin
              low_pw_q <= mid_pw_q;
              low_st_q <= mid_st_q;
            end
          end
          default: ;
        endcase
      end
      bits_pkg::ST_SQ1: begin
        p_q <= sq_rnd;
        t_q <= step_of(i_q);
      end
      bits_pkg::ST_LOWGET: begin
        low_pw_q <= PW'(ram_rdata);
        low_st_q <= step_of(i_q);
      end
      bits_pkg::ST_PMRND: begin
        mid_pw_q <= sq_rnd;
        mid_st_q <= low_st_q + step_of(j_q);
      end
      bits_pkg::ST_LOOP: begin
        if (i_q > IW'(1)) begin
          p_q <= mid_pw_q;
          t_q <= mid_st_q;
        end else begin
          p_q <= high_pw_q;
          t_q <= high_st_q;
        end
      end
      bits_pkg::ST_OUT: begin
        time_q <= (32'(t_q) > 32'd127) ? 7'd127 : 7'(t_q);
        ox_q   <= sat(ex);
        oy_q   <= sat(ey);
      end
      default: ;
    endcase
  end

  assign done_o           = done_q;
  assign intercept_time_o = time_q;
  assign intercept_x_o    = ox_q;
  assign intercept_y_o    = oy_q;

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == bits_pkg::ST_D0)) else $error("beat taken but no test started");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == bits_pkg::ST_IDLE)) else $error("result while searching");

  a_bisect_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bits_pkg::ST_D0 && mode_q == bits_pkg::MD_BISECT) |-> (i_q > IW'(1)))
    else $error("bisect test with exhausted index");

  a_no_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bits_pkg::ST_IDLE) |-> !pend_q && !div_busy)
    else $error("search running on stale reciprocal");

endmodule

// ===== hdl/bits_ram.sv =====
`timescale 1ns / 1ps

module bits_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/bits_recip.sv =====
`timescale 1ns / 1ps

// restoring divide, one quotient bit per cycle: (2^32 + gap/2) / gap
module bits_recip (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bits_pkg::PWR_W-1:0]     gap_i,
  output logic                           busy_o,
  output logic [bits_pkg::INV_W-1:0]     recip_o
);

  localparam int unsigned CW = $clog2(bits_pkg::INV_W + 1);
  localparam int unsigned INV_W = bits_pkg::INV_W;

  logic [CW-1:0]                cnt_q;
  logic [bits_pkg::PWR_W-1:0]   gap_q;
  logic [bits_pkg::PWR_W-1:0]   rem_q;
  logic [bits_pkg::INV_W-1:0]   num_q;
  logic [bits_pkg::INV_W-1:0]   quo_q;
  logic [bits_pkg::PWR_W:0]     rem_sh;
  logic                         fits;

  assign rem_sh  = {rem_q, num_q[bits_pkg::INV_W-1]};
  assign fits    = rem_sh >= {1'b0, gap_q};
  assign busy_o  = cnt_q != '0;
  assign recip_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(bits_pkg::INV_W);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gap_q <= gap_i;
      rem_q <= '0;
      num_q <= (INV_W'(1) << 32) + INV_W'(gap_i >> 1);
      quo_q <= '0;
    end else if (busy_o) begin
      rem_q <= fits ? bits_pkg::PWR_W'(rem_sh - {1'b0, gap_q})
                    : bits_pkg::PWR_W'(rem_sh);
      num_q <= num_q << 1;
      quo_q <= {quo_q[bits_pkg::INV_W-2:0], fits};
    end
  end

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o) else $error("divider did not start");

endmodule
